FILE: rtl/core/ecef_to_enu_rotation_unit_assert.svh
// ============================================================================
// Assertion macros for the ECEF-to-ENU rotation unit
// Shared property wrappers with a common clock, disable and report form.
// ============================================================================
`ifndef ECEF_TO_ENU_ROTATION_UNIT_ASSERT_SVH
`define ECEF_TO_ENU_ROTATION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define E2E_ASSERT_IMPL(name, clk, dis, ante, cons) \
    name: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("e2e assertion failed");

// Next-cycle implication.
`define E2E_ASSERT_NEXT(name, clk, dis, ante, cons) \
    name: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("e2e assertion failed");

`endif

FILE: rtl/core/e2e_pkg.sv
// ============================================================================
// e2e_pkg
// Widths, fixed-point constants and helpers of the ECEF-to-ENU rotation unit.
// ============================================================================
`timescale 1ns / 1ps

package e2e_pkg;

    localparam int IN_W             = 34;
    localparam int OUT_W            = 32;
    localparam int LEN_W            = 62;
    localparam int TRIG_W           = 34;
    localparam int PROD_W           = 2 * TRIG_W;
    localparam int SAT_W            = 40;
    localparam int SH_W             = 6;
    localparam int NORM_BIT         = 57;
    localparam int CORDIC_STEPS_DEF = 32;

    typedef logic signed [LEN_W-1:0]  t_len;
    typedef logic signed [TRIG_W-1:0] t_trig;

    localparam t_trig ONE_Q30      = 34'sd1073741824;
    localparam t_trig INV_GAIN_Q30 = 34'sd652032874;
    localparam logic [29:0] INV_GAIN_MAG = 30'd652032874;

    localparam t_len AB_DELTA_Q36 = 62'sd231178492;
    localparam t_len EP2B_Q4      = 62'sd685460984;
    localparam t_len E2A_Q4       = 62'sd683162763;

    localparam logic signed [OUT_W-1:0] OUT_ONE = 32'sd1073741824;

    // Clamp to [-1.0, 1.0] in Q2.30.
    function automatic logic signed [OUT_W-1:0] sat_q30(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] lim;
        lim = 40'sd1073741824;
        if (v > lim) begin
            return OUT_ONE;
        end else if (v < -lim) begin
            return -OUT_ONE;
        end
        return OUT_W'(v);
    endfunction

endpackage

FILE: rtl/core/e2e_pos_if.sv
// ============================================================================
// e2e_pos_if
// Position channel: one ECEF position per transaction.
// ============================================================================
`timescale 1ns / 1ps

interface e2e_pos_if;
    logic                               valid;
    logic                               ready;
    logic signed [e2e_pkg::IN_W-1:0]    ecef_x;
    logic signed [e2e_pkg::IN_W-1:0]    ecef_y;
    logic signed [e2e_pkg::IN_W-1:0]    ecef_z;

    modport source (output valid, output ecef_x, output ecef_y, output ecef_z, input ready);
    modport sink   (input valid, input ecef_x, input ecef_y, input ecef_z, output ready);
endinterface

FILE: rtl/core/e2e_mat_if.sv
// ============================================================================
// e2e_mat_if
// Rotation matrix channel: eight Q2.30 entries and a one-bit east_from_z per transaction.
// ============================================================================
`timescale 1ns / 1ps

interface e2e_mat_if;
    logic                               valid;
    logic                               ready;
    logic signed [e2e_pkg::OUT_W-1:0]   east_from_x;
    logic signed [e2e_pkg::OUT_W-1:0]   east_from_y;
    logic        [0:0]                  east_from_z;
    logic signed [e2e_pkg::OUT_W-1:0]   north_from_x;
    logic signed [e2e_pkg::OUT_W-1:0]   north_from_y;
    logic signed [e2e_pkg::OUT_W-1:0]   north_from_z;
    logic signed [e2e_pkg::OUT_W-1:0]   up_from_x;
    logic signed [e2e_pkg::OUT_W-1:0]   up_from_y;
    logic signed [e2e_pkg::OUT_W-1:0]   up_from_z;

    modport source (output valid, output east_from_x, output east_from_y, output east_from_z,
                    output north_from_x, output north_from_y, output north_from_z,
                    output up_from_x, output up_from_y, output up_from_z, input ready);
    modport sink   (input valid, input east_from_x, input east_from_y, input east_from_z,
                    input north_from_x, input north_from_y, input north_from_z,
                    input up_from_x, input up_from_y, input up_from_z, output ready);
endinterface

FILE: rtl/core/e2e_dir.sv
// ============================================================================
// e2e_dir
// Pipelined CORDIC direction finder: cos, sin and magnitude of a vector.
// ============================================================================
`timescale 1ns / 1ps

module e2e_dir #(
    parameter int STEPS = e2e_pkg::CORDIC_STEPS_DEF,
    parameter int SB_W  = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  e2e_pkg::t_len       i_x,
    input  e2e_pkg::t_len       i_y,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_vld,
    output e2e_pkg::t_trig      o_c,
    output e2e_pkg::t_trig      o_s,
    output e2e_pkg::t_len       o_r,
    output logic [SB_W-1:0]     o_sb
);

    localparam int LEN_W = e2e_pkg::LEN_W;
    localparam int SH_W  = e2e_pkg::SH_W;
    localparam int NB    = e2e_pkg::NORM_BIT;

    // Stage A: fold into the right half plane.
    logic                   r_a_vld, r_a_flip, r_a_zero;
    e2e_pkg::t_len          r_a_x, r_a_y;
    logic [SB_W-1:0]        r_a_sb;

    // Stage B: coarse normalization.
    e2e_pkg::t_len          n_b_x, n_b_y, r_b_x, r_b_y;
    logic [LEN_W-1:0]       n_b_m, r_b_m;
    logic [SH_W-1:0]        n_b_sh, r_b_sh;
    logic                   r_b_vld, r_b_flip, r_b_zero;
    logic [SB_W-1:0]        r_b_sb;

    // Stage C (fine normalization) writes micro-rotation slot 0.
    e2e_pkg::t_len          n_c_x, n_c_y;
    logic [LEN_W-1:0]       n_c_m;
    logic [SH_W-1:0]        n_c_sh;

    e2e_pkg::t_len          r_it_x   [0:STEPS];
    e2e_pkg::t_len          r_it_y   [0:STEPS];
    e2e_pkg::t_trig         r_it_c   [0:STEPS];
    e2e_pkg::t_trig         r_it_s   [0:STEPS];
    logic [SH_W-1:0]        r_it_sh  [0:STEPS];
    logic                   r_it_flip[0:STEPS];
    logic                   r_it_zero[0:STEPS];
    logic [SB_W-1:0]        r_it_sb  [0:STEPS];
    logic                   r_it_vld [0:STEPS];

    // Magnitude scaling stages D, E, F.
    logic [31:0]            w_xh;
    logic [29:0]            w_xl;
    e2e_pkg::t_trig         n_d_c, n_d_s;
    logic [LEN_W-1:0]       r_d_ph;
    logic [59:0]            r_d_pl;
    e2e_pkg::t_trig         r_d_c, r_d_s, r_e_c, r_e_s, r_f_c, r_f_s;
    logic [SH_W-1:0]        r_d_sh, r_e_sh;
    logic                   r_d_zero, r_e_zero;
    logic [SB_W-1:0]        r_d_sb, r_e_sb, r_f_sb;
    logic                   r_d_vld, r_e_vld, r_f_vld;
    logic [LEN_W-1:0]       r_e_mag;
    e2e_pkg::t_len          r_f_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_flip <= (i_x < 0);
            r_a_zero <= (i_x == '0) && (i_y == '0);
            r_a_x    <= (i_x < 0) ? -i_x : i_x;
            r_a_y    <= (i_x < 0) ? -i_y : i_y;
            r_a_sb   <= i_sb;
        end
    end

    always_comb begin
        n_b_x  = r_a_x;
        n_b_y  = r_a_y;
        n_b_m  = (r_a_y < 0) ? unsigned'(-r_a_y) : unsigned'(r_a_y);
        n_b_sh = '0;
        if (unsigned'(r_a_x) > n_b_m) begin
            n_b_m = unsigned'(r_a_x);
        end
        if (n_b_m[NB -: 32] == '0) begin
            n_b_x = n_b_x <<< 32;
            n_b_y = n_b_y <<< 32;
            n_b_m = n_b_m << 32;
            n_b_sh[5] = 1'b1;
        end
        if (n_b_m[NB -: 16] == '0) begin
            n_b_x = n_b_x <<< 16;
            n_b_y = n_b_y <<< 16;
            n_b_m = n_b_m << 16;
            n_b_sh[4] = 1'b1;
        end
        if (n_b_m[NB -: 8] == '0) begin
            n_b_x = n_b_x <<< 8;
            n_b_y = n_b_y <<< 8;
            n_b_m = n_b_m << 8;
            n_b_sh[3] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_x    <= n_b_x;
            r_b_y    <= n_b_y;
            r_b_m    <= n_b_m;
            r_b_sh   <= n_b_sh;
            r_b_flip <= r_a_flip;
            r_b_zero <= r_a_zero;
            r_b_sb   <= r_a_sb;
        end
    end

    always_comb begin
        n_c_x  = r_b_x;
        n_c_y  = r_b_y;
        n_c_m  = r_b_m;
        n_c_sh = r_b_sh;
        if (n_c_m[NB -: 4] == '0) begin
            n_c_x = n_c_x <<< 4;
            n_c_y = n_c_y <<< 4;
            n_c_m = n_c_m << 4;
            n_c_sh[2] = 1'b1;
        end
        if (n_c_m[NB -: 2] == '0) begin
            n_c_x = n_c_x <<< 2;
            n_c_y = n_c_y <<< 2;
            n_c_m = n_c_m << 2;
            n_c_sh[1] = 1'b1;
        end
        if (n_c_m[NB] == 1'b0) begin
            n_c_x = n_c_x <<< 1;
            n_c_y = n_c_y <<< 1;
            n_c_sh[0] = 1'b1;
        end
    end

    // The vectoring rotations are replayed on (1/K, 0) in the same stage, so
    // the unit vector comes out alongside the rotated input.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it_x[0]    <= n_c_x;
            r_it_y[0]    <= n_c_y;
            r_it_c[0]    <= e2e_pkg::INV_GAIN_Q30;
            r_it_s[0]    <= '0;
            r_it_sh[0]   <= n_c_sh;
            r_it_flip[0] <= r_b_flip;
            r_it_zero[0] <= r_b_zero;
            r_it_sb[0]   <= r_b_sb;
            for (int k = 0; k < STEPS; k++) begin
                if (r_it_y[k] >= 0) begin
                    r_it_x[k+1] <= r_it_x[k] + (r_it_y[k] >>> k);
                    r_it_y[k+1] <= r_it_y[k] - (r_it_x[k] >>> k);
                    r_it_c[k+1] <= r_it_c[k] - (r_it_s[k] >>> k);
                    r_it_s[k+1] <= r_it_s[k] + (r_it_c[k] >>> k);
                end else begin
                    r_it_x[k+1] <= r_it_x[k] - (r_it_y[k] >>> k);
                    r_it_y[k+1] <= r_it_y[k] + (r_it_x[k] >>> k);
                    r_it_c[k+1] <= r_it_c[k] + (r_it_s[k] >>> k);
                    r_it_s[k+1] <= r_it_s[k] - (r_it_c[k] >>> k);
                end
                r_it_sh[k+1]   <= r_it_sh[k];
                r_it_flip[k+1] <= r_it_flip[k];
                r_it_zero[k+1] <= r_it_zero[k];
                r_it_sb[k+1]   <= r_it_sb[k];
            end
        end
    end

    // The final x is positive; split it so each product stays near 32x30.
    assign w_xh = r_it_x[STEPS][LEN_W-1:30];
    assign w_xl = r_it_x[STEPS][29:0];

    always_comb begin
        if (r_it_zero[STEPS]) begin
            n_d_c = e2e_pkg::ONE_Q30;
            n_d_s = '0;
        end else if (r_it_flip[STEPS]) begin
            n_d_c = -r_it_c[STEPS];
            n_d_s = -r_it_s[STEPS];
        end else begin
            n_d_c = r_it_c[STEPS];
            n_d_s = r_it_s[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_ph   <= w_xh * e2e_pkg::INV_GAIN_MAG;
            r_d_pl   <= w_xl * e2e_pkg::INV_GAIN_MAG;
            r_d_c    <= n_d_c;
            r_d_s    <= n_d_s;
            r_d_sh   <= r_it_sh[STEPS];
            r_d_zero <= r_it_zero[STEPS];
            r_d_sb   <= r_it_sb[STEPS];

            r_e_mag  <= r_d_ph + LEN_W'(r_d_pl >> 30);
            r_e_c    <= r_d_c;
            r_e_s    <= r_d_s;
            r_e_sh   <= r_d_sh;
            r_e_zero <= r_d_zero;
            r_e_sb   <= r_d_sb;

            r_f_r    <= r_e_zero ? '0 : signed'(r_e_mag >> r_e_sh);
            r_f_c    <= r_e_c;
            r_f_s    <= r_e_s;
            r_f_sb   <= r_e_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            for (int k = 0; k <= STEPS; k++) begin
                r_it_vld[k] <= 1'b0;
            end
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld     <= i_vld;
            r_b_vld     <= r_a_vld;
            r_it_vld[0] <= r_b_vld;
            for (int k = 0; k < STEPS; k++) begin
                r_it_vld[k+1] <= r_it_vld[k];
            end
            r_d_vld <= r_it_vld[STEPS];
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    assign o_vld = r_f_vld;
    assign o_c   = r_f_c;
    assign o_s   = r_f_s;
    assign o_r   = r_f_r;
    assign o_sb  = r_f_sb;

endmodule

FILE: rtl/core/ecef_to_enu_rotation_unit.sv
// ============================================================================
// ecef_to_enu_rotation_unit
// WGS-84 ECEF position to ECEF-to-ENU rotation matrix, fully pipelined.
// ============================================================================
// The unit takes one position per clock while the output is not stalled and
// returns its eight Q2.30 matrix entries and a one-bit east_from_z entry.
// The pipeline is made of three CORDIC direction finders in series (longitude,
// parametric latitude, geodetic latitude), each with CORDIC_STEPS rotation
// stages plus six stages of normalization and magnitude scaling, of the cube
// stages between the last two and of the product stages after them. The whole
// pipeline holds while a finished matrix waits on the output; the input is
// ready whenever the output register is empty or being taken.
`timescale 1ns / 1ps

`include "ecef_to_enu_rotation_unit_assert.svh"

module ecef_to_enu_rotation_unit #(
    parameter int CORDIC_STEPS = e2e_pkg::CORDIC_STEPS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    e2e_pos_if.sink         i_pos,
    e2e_mat_if.source       o_mat
);

    localparam int LEN_W  = e2e_pkg::LEN_W;
    localparam int TRIG_W = e2e_pkg::TRIG_W;
    localparam int PROD_W = e2e_pkg::PROD_W;
    localparam int SAT_W  = e2e_pkg::SAT_W;
    localparam int OUT_W  = e2e_pkg::OUT_W;
    localparam int SB1_W  = 2 * LEN_W;
    localparam int SB2_W  = 2 * LEN_W + 2 * TRIG_W;
    localparam int SB3_W  = 2 * TRIG_W;

    logic w_en;

    // Input stage.
    logic                   r_t0_vld;
    e2e_pkg::t_len          r_t0_x16, r_t0_y16, r_t0_z16, r_t0_zmul;

    // Longitude finder.
    logic                   f1_vld;
    e2e_pkg::t_trig         f1_c, f1_s;
    e2e_pkg::t_len          f1_r;
    logic [SB1_W-1:0]       f1_sb;
    e2e_pkg::t_len          w_f1_z16, w_f1_zmul;

    // Scaled z and radial distance.
    logic                   r_t1_vld;
    e2e_pkg::t_len          r_t1_p16, r_t1_zr, r_t1_z16;
    e2e_pkg::t_trig         r_t1_cl, r_t1_sl;

    // Parametric latitude finder.
    logic                   f2_vld;
    e2e_pkg::t_trig         f2_c, f2_s;
    e2e_pkg::t_len          f2_r;
    logic [SB2_W-1:0]       f2_sb;
    e2e_pkg::t_len          w_f2_z16, w_f2_p16;
    e2e_pkg::t_trig         w_f2_cl, w_f2_sl;

    // Cube and correction stages.
    logic                   r_m1_vld, r_m2_vld, r_m3_vld, r_m4_vld;
    e2e_pkg::t_trig         r_m1_st, r_m1_ct, r_m1_sq, r_m1_cq;
    e2e_pkg::t_trig         r_m2_s3, r_m2_c3;
    e2e_pkg::t_len          r_m3_ps, r_m3_pc, r_m4_num, r_m4_den;
    e2e_pkg::t_len          r_m1_z16, r_m1_p16, r_m2_z16, r_m2_p16, r_m3_z16, r_m3_p16;
    e2e_pkg::t_trig         r_m1_cl, r_m1_sl, r_m2_cl, r_m2_sl;
    e2e_pkg::t_trig         r_m3_cl, r_m3_sl, r_m4_cl, r_m4_sl;

    // Geodetic latitude finder.
    logic                   f3_vld;
    e2e_pkg::t_trig         f3_c, f3_s;
    e2e_pkg::t_len          f3_r;
    logic [SB3_W-1:0]       f3_sb;
    e2e_pkg::t_trig         w_f3_cl, w_f3_sl;

    // Product and output stages.
    logic                   r_p_vld;
    logic signed [PROD_W-1:0] r_p_spcl, r_p_spsl, r_p_cpcl, r_p_cpsl;
    e2e_pkg::t_trig         r_p_cl, r_p_sl, r_p_cp, r_p_sp;

    logic                   r_o_vld;
    logic signed [OUT_W-1:0] r_o_ex, r_o_ey, r_o_nx, r_o_ny, r_o_nz;
    logic signed [OUT_W-1:0] r_o_ux, r_o_uy, r_o_uz;

    // The magnitudes of the second and third finders are not used.
    logic w_unused;

    assign w_en        = !r_o_vld || o_mat.ready;
    assign i_pos.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0_x16  <= LEN_W'(i_pos.ecef_x) <<< 16;
            r_t0_y16  <= LEN_W'(i_pos.ecef_y) <<< 16;
            r_t0_z16  <= LEN_W'(i_pos.ecef_z) <<< 16;
            r_t0_zmul <= LEN_W'(i_pos.ecef_z) * e2e_pkg::AB_DELTA_Q36;
        end
    end

    e2e_dir #(.STEPS(CORDIC_STEPS), .SB_W(SB1_W)) u_dir_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_t0_vld),
        .i_x     (r_t0_x16),
        .i_y     (r_t0_y16),
        .i_sb    ({r_t0_z16, r_t0_zmul}),
        .o_vld   (f1_vld),
        .o_c     (f1_c),
        .o_s     (f1_s),
        .o_r     (f1_r),
        .o_sb    (f1_sb)
    );

    assign w_f1_z16  = f1_sb[SB1_W-1 -: LEN_W];
    assign w_f1_zmul = f1_sb[LEN_W-1:0];

    // On the polar axis the finder reports a zero vector: cos 1, sin 0, p 0.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_p16 <= f1_r;
            r_t1_zr  <= w_f1_z16 + (w_f1_zmul >>> 20);
            r_t1_z16 <= w_f1_z16;
            r_t1_cl  <= f1_c;
            r_t1_sl  <= f1_s;
        end
    end

    e2e_dir #(.STEPS(CORDIC_STEPS), .SB_W(SB2_W)) u_dir_par (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_t1_vld),
        .i_x     (r_t1_p16),
        .i_y     (r_t1_zr),
        .i_sb    ({r_t1_z16, r_t1_p16, r_t1_cl, r_t1_sl}),
        .o_vld   (f2_vld),
        .o_c     (f2_c),
        .o_s     (f2_s),
        .o_r     (f2_r),
        .o_sb    (f2_sb)
    );

    assign w_f2_z16 = f2_sb[SB2_W-1 -: LEN_W];
    assign w_f2_p16 = f2_sb[SB2_W-LEN_W-1 -: LEN_W];
    assign w_f2_cl  = f2_sb[2*TRIG_W-1 -: TRIG_W];
    assign w_f2_sl  = f2_sb[TRIG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_st  <= f2_s;
            r_m1_ct  <= f2_c;
            r_m1_sq  <= TRIG_W'((PROD_W'(f2_s) * PROD_W'(f2_s)) >>> 30);
            r_m1_cq  <= TRIG_W'((PROD_W'(f2_c) * PROD_W'(f2_c)) >>> 30);
            r_m1_z16 <= w_f2_z16;
            r_m1_p16 <= w_f2_p16;
            r_m1_cl  <= w_f2_cl;
            r_m1_sl  <= w_f2_sl;

            r_m2_s3  <= TRIG_W'((PROD_W'(r_m1_sq) * PROD_W'(r_m1_st)) >>> 30);
            r_m2_c3  <= TRIG_W'((PROD_W'(r_m1_cq) * PROD_W'(r_m1_ct)) >>> 30);
            r_m2_z16 <= r_m1_z16;
            r_m2_p16 <= r_m1_p16;
            r_m2_cl  <= r_m1_cl;
            r_m2_sl  <= r_m1_sl;

            r_m3_ps  <= e2e_pkg::EP2B_Q4 * LEN_W'(r_m2_s3);
            r_m3_pc  <= e2e_pkg::E2A_Q4 * LEN_W'(r_m2_c3);
            r_m3_z16 <= r_m2_z16;
            r_m3_p16 <= r_m2_p16;
            r_m3_cl  <= r_m2_cl;
            r_m3_sl  <= r_m2_sl;

            r_m4_num <= r_m3_z16 + (r_m3_ps >>> 18);
            r_m4_den <= r_m3_p16 - (r_m3_pc >>> 18);
            r_m4_cl  <= r_m3_cl;
            r_m4_sl  <= r_m3_sl;
        end
    end

    e2e_dir #(.STEPS(CORDIC_STEPS), .SB_W(SB3_W)) u_dir_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_m4_vld),
        .i_x     (r_m4_den),
        .i_y     (r_m4_num),
        .i_sb    ({r_m4_cl, r_m4_sl}),
        .o_vld   (f3_vld),
        .o_c     (f3_c),
        .o_s     (f3_s),
        .o_r     (f3_r),
        .o_sb    (f3_sb)
    );

    assign w_f3_cl = f3_sb[SB3_W-1 -: TRIG_W];
    assign w_f3_sl = f3_sb[TRIG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_spcl <= PROD_W'(f3_s) * PROD_W'(w_f3_cl);
            r_p_spsl <= PROD_W'(f3_s) * PROD_W'(w_f3_sl);
            r_p_cpcl <= PROD_W'(f3_c) * PROD_W'(w_f3_cl);
            r_p_cpsl <= PROD_W'(f3_c) * PROD_W'(w_f3_sl);
            r_p_cl   <= w_f3_cl;
            r_p_sl   <= w_f3_sl;
            r_p_cp   <= f3_c;
            r_p_sp   <= f3_s;

            // Negated entries negate the already floored product.
            r_o_ex <= e2e_pkg::sat_q30(-SAT_W'(r_p_sl));
            r_o_ey <= e2e_pkg::sat_q30(SAT_W'(r_p_cl));
            r_o_nx <= e2e_pkg::sat_q30(-SAT_W'(r_p_spcl >>> 30));
            r_o_ny <= e2e_pkg::sat_q30(-SAT_W'(r_p_spsl >>> 30));
            r_o_nz <= e2e_pkg::sat_q30(SAT_W'(r_p_cp));
            r_o_ux <= e2e_pkg::sat_q30(SAT_W'(r_p_cpcl >>> 30));
            r_o_uy <= e2e_pkg::sat_q30(SAT_W'(r_p_cpsl >>> 30));
            r_o_uz <= e2e_pkg::sat_q30(SAT_W'(r_p_sp));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_vld <= 1'b0;
            r_t1_vld <= 1'b0;
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
            r_m4_vld <= 1'b0;
            r_p_vld  <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_t0_vld <= i_pos.valid;
            r_t1_vld <= f1_vld;
            r_m1_vld <= f2_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
            r_m4_vld <= r_m3_vld;
            r_p_vld  <= f3_vld;
            r_o_vld  <= r_p_vld;
        end
    end

    assign o_mat.valid        = r_o_vld;
    assign o_mat.east_from_x  = r_o_ex;
    assign o_mat.east_from_y  = r_o_ey;
    assign o_mat.east_from_z  = 1'b0;
    assign o_mat.north_from_x = r_o_nx;
    assign o_mat.north_from_y = r_o_ny;
    assign o_mat.north_from_z = r_o_nz;
    assign o_mat.up_from_x    = r_o_ux;
    assign o_mat.up_from_y    = r_o_uy;
    assign o_mat.up_from_z    = r_o_uz;

    assign w_unused = ^{f2_r, f3_r};

    `E2E_ASSERT_NEXT(a_rst_clears, i_clk, 1'b0, !i_rst_n, !r_o_vld && !r_t0_vld)
    `E2E_ASSERT_NEXT(a_stall_holds, i_clk, !i_rst_n, r_t0_vld && !w_en,
                     r_t0_vld && $stable(r_t0_x16))
    `E2E_ASSERT_IMPL(a_full_blocks_in, i_clk, !i_rst_n, r_o_vld && !o_mat.ready,
                     !i_pos.ready)
    `E2E_ASSERT_IMPL(a_cos_lat_range, i_clk, !i_rst_n, r_o_vld,
                     (r_o_nz <= e2e_pkg::OUT_ONE) && (r_o_nz >= -e2e_pkg::OUT_ONE))

endmodule

FILE: tb/sv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the ECEF-to-ENU rotation unit. Each accepted position
// is run through a fixed-point predictor that follows the block's CORDIC
// arithmetic, and the expected matrix is queued. Every returned matrix is
// then compared entry by entry with the oldest queued one. Both channels idle
// at random.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int  IN_W          = e2e_pkg::IN_W;
    localparam int  OUT_W         = e2e_pkg::OUT_W;
    localparam int  NORM_BIT      = e2e_pkg::NORM_BIT;
    localparam int  STEPS         = e2e_pkg::CORDIC_STEPS_DEF;
    localparam int  PIPE_LATENCY  = 3 * STEPS + 26;
    localparam int  WATCHDOG_MAX  = 4000;
    localparam int  RANDOM_ITEMS  = 1920;
    localparam longint INV_GAIN   = 652032874;
    localparam longint Q30_ONE    = 1073741824;
    localparam longint AB_DELTA   = 231178492;
    localparam longint EP2B       = 685460984;
    localparam longint E2A        = 683162763;
    localparam longint EARTH_A_MM = 64'sd6378137000;

    typedef struct {
        logic signed [OUT_W-1:0] east_x;
        logic signed [OUT_W-1:0] east_y;
        logic                    east_z;
        logic signed [OUT_W-1:0] north_x;
        logic signed [OUT_W-1:0] north_y;
        logic signed [OUT_W-1:0] north_z;
        logic signed [OUT_W-1:0] up_x;
        logic signed [OUT_W-1:0] up_y;
        logic signed [OUT_W-1:0] up_z;
    } t_enu_matrix;

    logic i_clk;
    logic i_rst_n;

    e2e_pos_if pos_ch ();
    e2e_mat_if mat_ch ();

    ecef_to_enu_rotation_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pos   (pos_ch),
        .o_mat   (mat_ch)
    );

    t_enu_matrix pending_mats[$];
    int          error_count;
    int          positions_sent;
    int          matrices_checked;
    int          polar_count;
    int          idle_cycles;
    int          ready_hold;
    bit          sender_busy_mode;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint q30_product(input longint v, input longint k);
        longint hi;
        longint lo;
        hi = v >>> 30;
        lo = v & 64'h3FFF_FFFF;
        return hi * k + ((lo * k) >>> 30);
    endfunction

    // Vectoring CORDIC: cos/sin of atan2(y, x) in Q30 and the vector length.
    function automatic void vector_angle(input longint x_in, input longint y_in,
                                         output longint cos_q, output longint sin_q,
                                         output longint length);
        longint x;
        longint y;
        longint mag;
        longint cc;
        longint ss;
        longint nx;
        longint ny;
        longint nc;
        longint ns;
        int     norm_shift;
        bit     flipped;
        x = x_in;
        y = y_in;
        cc = INV_GAIN;
        ss = 0;
        norm_shift = 0;
        if (x == 0 && y == 0) begin
            cos_q = Q30_ONE;
            sin_q = 0;
            length = 0;
            return;
        end
        flipped = (x < 0);
        if (flipped) begin
            x = -x;
            y = -y;
        end
        mag = (y < 0) ? -y : y;
        if (x > mag) begin
            mag = x;
        end
        while (mag < (64'sd1 <<< NORM_BIT)) begin
            x = x * 2;
            y = y * 2;
            mag = mag * 2;
            norm_shift++;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                nc = cc - (ss >>> i);
                ns = ss + (cc >>> i);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                nc = cc + (ss >>> i);
                ns = ss - (cc >>> i);
            end
            x = nx;
            y = ny;
            cc = nc;
            ss = ns;
        end
        if (flipped) begin
            cc = -cc;
            ss = -ss;
        end
        cos_q = cc;
        sin_q = ss;
        length = q30_product(x, INV_GAIN) >>> norm_shift;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_q30(input longint v);
        if (v > Q30_ONE) begin
            v = Q30_ONE;
        end else if (v < -Q30_ONE) begin
            v = -Q30_ONE;
        end
        return OUT_W'(v);
    endfunction

    function automatic t_enu_matrix predict_enu_matrix(input logic signed [IN_W-1:0] ex,
                                                       input logic signed [IN_W-1:0] ey,
                                                       input logic signed [IN_W-1:0] ez);
        longint x;
        longint y;
        longint z;
        longint cos_lon;
        longint sin_lon;
        longint p_q16;
        longint cos_th;
        longint sin_th;
        longint cos_lat;
        longint sin_lat;
        longint unused_len;
        longint z_scaled;
        longint sin3;
        longint cos3;
        longint num;
        longint den;
        t_enu_matrix m;
        x = longint'(ex);
        y = longint'(ey);
        z = longint'(ez);
        if (x == 0 && y == 0) begin
            cos_lon = Q30_ONE;
            sin_lon = 0;
            p_q16 = 0;
        end else begin
            vector_angle(x * 65536, y * 65536, cos_lon, sin_lon, p_q16);
        end
        // Parametric latitude uses z stretched by a/b.
        z_scaled = z * 65536 + ((z * AB_DELTA) >>> 20);
        vector_angle(p_q16, z_scaled, cos_th, sin_th, unused_len);
        sin3 = (((sin_th * sin_th) >>> 30) * sin_th) >>> 30;
        cos3 = (((cos_th * cos_th) >>> 30) * cos_th) >>> 30;
        num = z * 65536 + ((EP2B * sin3) >>> 18);
        den = p_q16 - ((E2A * cos3) >>> 18);
        vector_angle(den, num, cos_lat, sin_lat, unused_len);
        m.east_x  = clamp_q30(-sin_lon);
        m.east_y  = clamp_q30(cos_lon);
        m.east_z  = 1'b0;
        m.north_x = clamp_q30(-((sin_lat * cos_lon) >>> 30));
        m.north_y = clamp_q30(-((sin_lat * sin_lon) >>> 30));
        m.north_z = clamp_q30(cos_lat);
        m.up_x    = clamp_q30((cos_lat * cos_lon) >>> 30);
        m.up_y    = clamp_q30((cos_lat * sin_lon) >>> 30);
        m.up_z    = clamp_q30(sin_lat);
        return m;
    endfunction

    // ---------------------------------------------------------------- monitors

    function automatic void queue_expected(input t_enu_matrix m);
        pending_mats = {pending_mats, m};
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pos_ch.valid && pos_ch.ready) begin
            queue_expected(predict_enu_matrix(pos_ch.ecef_x, pos_ch.ecef_y,
                                              pos_ch.ecef_z));
            positions_sent++;
            if (pos_ch.ecef_x == 0 && pos_ch.ecef_y == 0) begin
                polar_count++;
            end
        end
    end

    task automatic compare_entry(input string name, input logic signed [OUT_W-1:0] exp_v,
                                 input logic signed [OUT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_enu_matrix exp_m;
        if (i_rst_n && mat_ch.valid && mat_ch.ready) begin
            if (pending_mats.size() == 0) begin
                $error("matrix returned with no position outstanding");
                error_count++;
            end else begin
                exp_m = pending_mats.pop_front();
                compare_entry("east_from_x", exp_m.east_x, mat_ch.east_from_x);
                compare_entry("east_from_y", exp_m.east_y, mat_ch.east_from_y);
                compare_entry("east_from_z", OUT_W'(exp_m.east_z), OUT_W'(mat_ch.east_from_z));
                compare_entry("north_from_x", exp_m.north_x, mat_ch.north_from_x);
                compare_entry("north_from_y", exp_m.north_y, mat_ch.north_from_y);
                compare_entry("north_from_z", exp_m.north_z, mat_ch.north_from_z);
                compare_entry("up_from_x", exp_m.up_x, mat_ch.up_from_x);
                compare_entry("up_from_y", exp_m.up_y, mat_ch.up_from_y);
                compare_entry("up_from_z", exp_m.up_z, mat_ch.up_from_z);
                matrices_checked++;
            end
        end
    end

    // The sink stalls a random number of cycles after each transaction, except
    // while the bench runs in back-to-back mode.
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            mat_ch.ready <= 1'b0;
            ready_hold <= 0;
        end else if (mat_ch.valid && mat_ch.ready) begin
            draw = sender_busy_mode ? 0 : $urandom_range(0, 11);
            if (draw == 0) begin
                mat_ch.ready <= 1'b1;
            end else begin
                ready_hold <= draw - 1;
                mat_ch.ready <= 1'b0;
            end
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            mat_ch.ready <= 1'b0;
        end else begin
            mat_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((pos_ch.valid && pos_ch.ready) || (mat_ch.valid && mat_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("FAIL ecef_to_enu_rotation_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_position(input logic signed [IN_W-1:0] ex,
                                 input logic signed [IN_W-1:0] ey,
                                 input logic signed [IN_W-1:0] ez);
        int gap;
        gap = sender_busy_mode ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            pos_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pos_ch.valid  <= 1'b1;
        pos_ch.ecef_x <= ex;
        pos_ch.ecef_y <= ey;
        pos_ch.ecef_z <= ez;
        @(posedge i_clk);
        while (!pos_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [IN_W-1:0] random_coord();
        logic [63:0] raw;
        int          mode;
        raw = {$urandom, $urandom};
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            // Within the earth's radius, any sign.
            return IN_W'($signed(raw[32:0]) % EARTH_A_MM);
        end else if (mode < 7) begin
            return IN_W'($signed(raw[IN_W-1:0]) >>> $urandom_range(0, 33));
        end else if (mode == 7) begin
            return IN_W'($urandom_range(0, 3)) - 2;
        end
        return raw[IN_W-1:0];
    endfunction

    task automatic test_directed();
        logic signed [IN_W-1:0] mx;
        logic signed [IN_W-1:0] mn;
        logic signed [IN_W-1:0] ra;
        mx = {1'b0, {(IN_W-1){1'b1}}};
        mn = {1'b1, {(IN_W-1){1'b0}}};
        ra = IN_W'(EARTH_A_MM);
        send_position(0, 0, 0);
        send_position(0, 0, mx);
        send_position(0, 0, mn);
        send_position(0, 0, 1);
        send_position(0, 0, -1);
        send_position(ra, 0, 0);
        send_position(-ra, 0, 0);
        send_position(0, ra, 0);
        send_position(0, -ra, 0);
        send_position(mx, mx, mx);
        send_position(mn, mn, mn);
        send_position(mx, mn, 0);
        send_position(mn, mx, mx);
        send_position(mn, 0, 0);
        send_position(1, 0, 0);
        send_position(-1, 0, 0);
        send_position(0, 1, 0);
        send_position(-1, -1, 1);
        send_position(ra, ra, ra);
        send_position(-ra, ra, -ra);
        send_position(mx, 0, mn);
        send_position(1, 1, mx);
    endtask

    task automatic test_random_positions(input int count);
        for (int n = 0; n < count; n++) begin
            // Occasional back-to-back stretches with no idling on either side.
            if (n % 150 == 0) begin
                sender_busy_mode = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 19) == 0) begin
                send_position(0, 0, random_coord());
            end else begin
                send_position(random_coord(), random_coord(), random_coord());
            end
        end
        sender_busy_mode = 1'b0;
    endtask

    task automatic test_drain_pause();
        pos_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_mats.size() != 0) begin
            @(posedge i_clk);
        end
        send_position(IN_W'(EARTH_A_MM), 1000, -1000);
    endtask

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        pos_ch.valid     = 1'b0;
        pos_ch.ecef_x    = '0;
        pos_ch.ecef_y    = '0;
        pos_ch.ecef_z    = '0;
        mat_ch.ready     = 1'b0;
        error_count      = 0;
        positions_sent   = 0;
        matrices_checked = 0;
        polar_count      = 0;
        idle_cycles      = 0;
        ready_hold       = 0;
        sender_busy_mode = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_positions(RANDOM_ITEMS / 2);
        test_drain_pause();
        test_random_positions(RANDOM_ITEMS / 2);

        pos_ch.valid <= 1'b0;
        while (pending_mats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        $display("Covered %0d positions (%0d on the polar axis), %0d matrices checked.",
                 positions_sent, polar_count, matrices_checked);
        $display("Random idling on both channels, back-to-back bursts and a full drain.");
        if (error_count == 0) begin
            $display("PASS ecef_to_enu_rotation_unit");
        end else begin
            $display("FAIL ecef_to_enu_rotation_unit");
        end
        $finish;
    end

endmodule
